### src/gfsr_pkg.sv
// Shared types and constants for the lagged-XOR GFSR generator.
// No dependencies; used by every module of the block.
package gfsr_pkg;

  localparam int LONG_LAG  = 127;
  localparam int SHORT_LAG = 97;
  localparam int LAG_GAP   = LONG_LAG - SHORT_LAG;
  localparam int WORD_BITS = 32;
  localparam int MAX_RUN   = 64;
  localparam int IDX_W     = 7;
  localparam int CNT_W     = 7;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_GEN  = 1'b1;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_GEN  = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic                 wr_en;
    logic [IDX_W-1:0]     idx;
    logic [WORD_BITS-1:0] word;
    logic [CNT_W-1:0]     count;
  } cmd_t;

  typedef struct packed {
    logic idle;
    logic rd_pending;
  } back_stat_t;

endpackage

### src/gfsr_front.sv
// Front end: accepts input beats, classifies them into commands and queues them.
// Depends on gfsr_pkg.
module gfsr_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  logic                           opcode,
  input  logic [gfsr_pkg::IDX_W-1:0]     seed_index,
  input  logic [gfsr_pkg::WORD_BITS-1:0] seed_word,
  input  logic [gfsr_pkg::CNT_W-1:0]     count,
  output logic                           cmd_valid,
  input  logic                           cmd_ready,
  output gfsr_pkg::cmd_t                 cmd
);

  gfsr_pkg::cmd_t queue [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;
  gfsr_pkg::cmd_t cls;
  logic       keep;
  logic       push;
  logic       pop;

  always_comb begin
    cls.kind  = (opcode == gfsr_pkg::OP_GEN) ? gfsr_pkg::KIND_GEN : gfsr_pkg::KIND_LOAD;
    cls.wr_en = (seed_index < gfsr_pkg::IDX_W'(gfsr_pkg::LONG_LAG));
    cls.idx   = seed_index;
    cls.word  = seed_word;
    cls.count = (count > gfsr_pkg::CNT_W'(gfsr_pkg::MAX_RUN)) ?
                gfsr_pkg::CNT_W'(gfsr_pkg::MAX_RUN) : count;
    // zero-length runs have no effect at all
    keep = (opcode == gfsr_pkg::OP_LOAD) || (count != '0);
  end

  assign item_ready = (fill != 2'd2);
  assign push       = item_valid && item_ready && keep;
  assign cmd_valid  = (fill != 2'd0);
  assign pop        = cmd_valid && cmd_ready;
  assign cmd        = queue[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

### src/gfsr_back.sv
// Back end: ring memory, read/XOR/write-back pipeline and output register.
// Depends on gfsr_pkg.
module gfsr_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  output logic                           cmd_ready,
  input  gfsr_pkg::cmd_t                 cmd,
  output logic                           word_valid,
  input  logic                           word_ready,
  output logic [gfsr_pkg::WORD_BITS-1:0] random_word,
  output logic                           last_of_run,
  output gfsr_pkg::back_stat_t           status
);

  logic [gfsr_pkg::WORD_BITS-1:0] ring [gfsr_pkg::LONG_LAG];

  logic [gfsr_pkg::IDX_W-1:0]     pos;
  logic [gfsr_pkg::IDX_W-1:0]     pos_next;
  logic [gfsr_pkg::IDX_W:0]       q_sum;
  logic [gfsr_pkg::IDX_W-1:0]     q_addr;
  logic [gfsr_pkg::CNT_W-1:0]     remain;

  logic                           rd_valid;
  logic [gfsr_pkg::WORD_BITS-1:0] rd_a;
  logic [gfsr_pkg::WORD_BITS-1:0] rd_b;
  logic [gfsr_pkg::IDX_W-1:0]     rd_addr;
  logic                           rd_last;

  logic take_cmd;
  logic issue;
  logic rd_take;
  logic mem_we;
  logic [gfsr_pkg::IDX_W-1:0]     mem_waddr;
  logic [gfsr_pkg::WORD_BITS-1:0] mem_wdata;
  logic [gfsr_pkg::WORD_BITS-1:0] new_word;

  assign cmd_ready = (remain == '0) && !rd_valid;
  assign take_cmd  = cmd_valid && cmd_ready;
  assign rd_take   = rd_valid && (!word_valid || word_ready);
  assign issue     = (remain != '0) && (!rd_valid || rd_take);
  assign new_word  = rd_a ^ rd_b;

  always_comb begin
    q_sum  = {1'b0, pos} + (gfsr_pkg::IDX_W + 1)'(gfsr_pkg::LAG_GAP);
    q_addr = (q_sum >= (gfsr_pkg::IDX_W + 1)'(gfsr_pkg::LONG_LAG)) ?
             gfsr_pkg::IDX_W'(q_sum - (gfsr_pkg::IDX_W + 1)'(gfsr_pkg::LONG_LAG)) :
             q_sum[gfsr_pkg::IDX_W-1:0];
    pos_next = (pos == gfsr_pkg::IDX_W'(gfsr_pkg::LONG_LAG - 1)) ? '0 : pos + 1'b1;
  end

  // loads only land while the pipeline is empty, so one write port suffices
  always_comb begin
    if (rd_take) begin
      mem_we    = 1'b1;
      mem_waddr = rd_addr;
      mem_wdata = new_word;
    end else begin
      mem_we    = take_cmd && (cmd.kind == gfsr_pkg::KIND_LOAD) && cmd.wr_en;
      mem_waddr = cmd.idx;
      mem_wdata = cmd.word;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rd_a <= ring[pos];
      rd_b <= ring[q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_addr <= pos;
      rd_last <= (remain == gfsr_pkg::CNT_W'(1));
    end
    if (rd_take) begin
      random_word <= new_word;
      last_of_run <= rd_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      remain     <= '0;
      rd_valid   <= 1'b0;
      word_valid <= 1'b0;
    end else begin
      if (take_cmd) begin
        if (cmd.kind == gfsr_pkg::KIND_LOAD) begin
          pos <= '0;
        end else begin
          remain <= cmd.count;
        end
      end else if (issue) begin
        pos    <= pos_next;
        remain <= remain - 1'b1;
      end

      if (issue) rd_valid <= 1'b1;
      else if (rd_take) rd_valid <= 1'b0;

      if (rd_take) word_valid <= 1'b1;
      else if (word_ready) word_valid <= 1'b0;
    end
  end

  assign status.idle       = cmd_ready;
  assign status.rd_pending = rd_valid;

endmodule

### src/gfsr_xor_127_97_generator.sv
// Top level of the lagged-XOR GFSR generator (lags 127 and 97).
// Depends on gfsr_pkg, gfsr_front and gfsr_back.
//
// A load beat (opcode 0) writes one 32-bit seed word into the 127-entry ring and
// rewinds the ring position; it produces no output. A generate beat (opcode 1)
// produces count words (saturated to 64, zero does nothing), one per cycle when
// the output side keeps up, the last flagged by last_of_run. A run occupies the
// engine from taking the command through its ring reads until the last write-back
// has drained and the single write port is free for the next command. A two-entry
// command queue lets the next beats be taken meanwhile.
// All 127 entries must be loaded before the first generate.
module gfsr_xor_127_97_generator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  logic                           opcode,
  input  logic [gfsr_pkg::IDX_W-1:0]     seed_index,
  input  logic [gfsr_pkg::WORD_BITS-1:0] seed_word,
  input  logic [gfsr_pkg::CNT_W-1:0]     count,
  output logic                           word_valid,
  input  logic                           word_ready,
  output logic [gfsr_pkg::WORD_BITS-1:0] random_word,
  output logic                           last_of_run
);

  logic                 cmd_valid;
  logic                 cmd_ready;
  gfsr_pkg::cmd_t       cmd;
  gfsr_pkg::back_stat_t status;

  gfsr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .opcode     (opcode),
    .seed_index (seed_index),
    .seed_word  (seed_word),
    .count      (count),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd)
  );

  gfsr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .word_valid  (word_valid),
    .word_ready  (word_ready),
    .random_word (random_word),
    .last_of_run (last_of_run),
    .status      (status)
  );

  a_cmd_only_when_drained: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |-> (status.idle && !status.rd_pending))
    else $error("command taken while a run is in flight");

  a_run_length_legal: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready && cmd.kind == gfsr_pkg::KIND_GEN) |->
      (cmd.count != '0 && cmd.count <= gfsr_pkg::CNT_W'(gfsr_pkg::MAX_RUN)))
    else $error("generate command with illegal run length");

  a_no_output_after_reset: assert property (@(posedge clk)
    rst |=> !word_valid)
    else $error("output beat valid right after reset");

endmodule

### bench/gfsr_xor_127_97_generator_tb.sv
// Self-checking bench for gfsr_xor_127_97_generator: seed loads, directed table, random beats.
// Depends on gfsr_pkg and the generator RTL; output words checked against an in-bench ring model.
module gfsr_xor_127_97_generator_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_BEATS = 36;

  typedef struct packed {
    logic                           last;
    logic [gfsr_pkg::WORD_BITS-1:0] word;
  } gen_word_t;

  typedef struct packed {
    logic                           op;
    logic [gfsr_pkg::IDX_W-1:0]     idx;
    logic [gfsr_pkg::WORD_BITS-1:0] word;
    logic [gfsr_pkg::CNT_W-1:0]     cnt;
    logic                           typed;
    logic [gfsr_pkg::WORD_BITS-1:0] typed_word;
  } stim_row_t;

  logic                           clk;
  logic                           rst;
  logic                           item_valid;
  logic                           item_ready;
  logic                           opcode;
  logic [gfsr_pkg::IDX_W-1:0]     seed_index;
  logic [gfsr_pkg::WORD_BITS-1:0] seed_word;
  logic [gfsr_pkg::CNT_W-1:0]     count;
  logic                           word_valid;
  logic                           word_ready;
  logic [gfsr_pkg::WORD_BITS-1:0] random_word;
  logic                           last_of_run;

  logic [gfsr_pkg::WORD_BITS-1:0] ring_model [gfsr_pkg::LONG_LAG];
  logic [gfsr_pkg::IDX_W-1:0]     ring_pos;
  gen_word_t                      pending_words [$];

  bit quiet;
  int errors;
  int mismatches;
  int beats_sent;
  int loads_sent;
  int words_checked;
  int cycles;

  // typed rows assume the ring was cleared by the zero sweep
  stim_row_t directed_rows [0:16] = '{
    '{gfsr_pkg::OP_LOAD, 7'd0,   32'hFFFF_FFFF, 7'd0,   1'b0, 32'h0},
    '{gfsr_pkg::OP_LOAD, 7'd30,  32'h0000_FFFF, 7'd127, 1'b0, 32'h0},
    '{gfsr_pkg::OP_GEN,  7'd127, 32'hFFFF_FFFF, 7'd1,   1'b1, 32'hFFFF_0000},
    '{gfsr_pkg::OP_GEN,  7'd0,   32'h0,         7'd1,   1'b1, 32'h0000_0000},
    '{gfsr_pkg::OP_LOAD, 7'd127, 32'hDEAD_BEEF, 7'd5,   1'b0, 32'h0},
    '{gfsr_pkg::OP_GEN,  7'd0,   32'h0,         7'd1,   1'b1, 32'hFFFF_FFFF},
    '{gfsr_pkg::OP_GEN,  7'd0,   32'h0,         7'd0,   1'b0, 32'h0},
    '{gfsr_pkg::OP_LOAD, 7'd126, 32'h1234_5678, 7'd0,   1'b0, 32'h0},
    '{gfsr_pkg::OP_LOAD, 7'd96,  32'h8765_4321, 7'd0,   1'b0, 32'h0},
    '{gfsr_pkg::OP_GEN,  7'd0,   32'h0,         7'd64,  1'b0, 32'h0},
    '{gfsr_pkg::OP_GEN,  7'd0,   32'h0,         7'd100, 1'b0, 32'h0},
    '{gfsr_pkg::OP_GEN,  7'd0,   32'h0,         7'd127, 1'b0, 32'h0},
    '{gfsr_pkg::OP_GEN,  7'd0,   32'h0,         7'd2,   1'b0, 32'h0},
    '{gfsr_pkg::OP_LOAD, 7'd85,  32'hAAAA_AAAA, 7'd0,   1'b0, 32'h0},
    '{gfsr_pkg::OP_GEN,  7'd0,   32'h0,         7'd65,  1'b0, 32'h0},
    '{gfsr_pkg::OP_LOAD, 7'd42,  32'h5555_5555, 7'd0,   1'b0, 32'h0},
    '{gfsr_pkg::OP_GEN,  7'd0,   32'h0,         7'd3,   1'b0, 32'h0}
  };

  gfsr_xor_127_97_generator uut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .opcode     (opcode),
    .seed_index (seed_index),
    .seed_word  (seed_word),
    .count      (count),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .random_word(random_word),
    .last_of_run(last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // lagged XOR ring: new word = ring[p] ^ ring[p + 30], written back at p
  function automatic void run_ring(input logic op, input logic [gfsr_pkg::IDX_W-1:0] idx,
                                   input logic [gfsr_pkg::WORD_BITS-1:0] word,
                                   input logic [gfsr_pkg::CNT_W-1:0] cnt);
    int n;
    int q;
    logic [gfsr_pkg::WORD_BITS-1:0] v;
    if (op == gfsr_pkg::OP_LOAD) begin
      if (idx < gfsr_pkg::LONG_LAG) ring_model[idx] = word;
      ring_pos = '0;
    end else begin
      n = (cnt > gfsr_pkg::MAX_RUN) ? gfsr_pkg::MAX_RUN : int'(cnt);
      for (int k = 0; k < n; k++) begin
        q = (int'(ring_pos) + gfsr_pkg::LAG_GAP) % gfsr_pkg::LONG_LAG;
        v = ring_model[ring_pos] ^ ring_model[q];
        ring_model[ring_pos] = v;
        ring_pos = (ring_pos == gfsr_pkg::LONG_LAG - 1) ? '0 : ring_pos + 1'b1;
        pending_words.push_back('{last: (k == n - 1), word: v});
      end
    end
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_beat(input logic op, input logic [gfsr_pkg::IDX_W-1:0] idx,
                           input logic [gfsr_pkg::WORD_BITS-1:0] word,
                           input logic [gfsr_pkg::CNT_W-1:0] cnt,
                           input logic typed, input logic [gfsr_pkg::WORD_BITS-1:0] typed_word);
    while (!quiet && $urandom_range(99) < 7) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item_valid = 1'b1;
    opcode     = op;
    seed_index = idx;
    seed_word  = word;
    count      = cnt;
    do @(posedge clk); while (!item_ready);
    run_ring(op, idx, word, cnt);
    if (typed) begin
      void'(pending_words.pop_back());
      pending_words.push_back('{last: 1'b1, word: typed_word});
    end
    beats_sent++;
    if (op == gfsr_pkg::OP_LOAD) loads_sent++;
    @(negedge clk);
  endtask

  task automatic seed_ring(input bit random_fill);
    for (int i = 0; i < gfsr_pkg::LONG_LAG; i++)
      send_beat(gfsr_pkg::OP_LOAD, gfsr_pkg::IDX_W'(i), random_fill ? $urandom : '0,
                gfsr_pkg::CNT_W'($urandom), 1'b0, '0);
  endtask

  always @(negedge clk) begin
    word_ready = quiet || ($urandom_range(99) >= 7);
  end

  always @(posedge clk) begin
    gen_word_t exp_w;
    if (!rst && word_valid && word_ready) begin
      if (pending_words.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: word %h last %b", random_word, last_of_run);
      end else begin
        exp_w = pending_words.pop_front();
        words_checked++;
        if (random_word !== exp_w.word || last_of_run !== exp_w.last) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at word %0d: expected %h last %b, got %h last %b",
                     words_checked, exp_w.word, exp_w.last, random_word, last_of_run);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, pending_words.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic                           op;
    logic [gfsr_pkg::IDX_W-1:0]     ix;
    logic [gfsr_pkg::WORD_BITS-1:0] w;
    logic [gfsr_pkg::CNT_W-1:0]     cn;
    int                             pick;
    rst        = 1'b1;
    item_valid = 1'b0;
    opcode     = gfsr_pkg::OP_LOAD;
    seed_index = '0;
    seed_word  = '0;
    count      = '0;
    word_ready = 1'b0;
    quiet      = 1'b0;
    ring_pos   = '0;
    for (int i = 0; i < gfsr_pkg::LONG_LAG; i++) ring_model[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    seed_ring(1'b0);
    foreach (directed_rows[r])
      send_beat(directed_rows[r].op, directed_rows[r].idx, directed_rows[r].word,
                directed_rows[r].cnt, directed_rows[r].typed, directed_rows[r].typed_word);

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      quiet = (i >= 12 && i < 28);
      w     = $urandom;
      if ($urandom_range(99) < 35) begin
        op = gfsr_pkg::OP_LOAD;
        ix = ($urandom_range(19) == 0) ? gfsr_pkg::IDX_W'(gfsr_pkg::LONG_LAG) :
                                         gfsr_pkg::IDX_W'($urandom_range(126));
        cn = gfsr_pkg::CNT_W'($urandom);
      end else begin
        op   = gfsr_pkg::OP_GEN;
        ix   = gfsr_pkg::IDX_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 70)      cn = gfsr_pkg::CNT_W'($urandom_range(8, 1));
        else if (pick < 88) cn = gfsr_pkg::CNT_W'($urandom_range(64, 9));
        else if (pick < 94) cn = '0;
        else                cn = gfsr_pkg::CNT_W'($urandom_range(127, 65));
      end
      send_beat(op, ix, w, cn, 1'b0, '0);
    end
    quiet      = 1'b0;
    item_valid = 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_words.size() != 0) errors++;

    $display("sent %0d beats (%0d seed loads), checked %0d generated words",
             beats_sent, loads_sent, words_checked);
    $display("covered ring wrap, out-of-range loads, zero and saturated run lengths");
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
